/* design/assert_macros.svh */
// Assertion helpers, included by palette_box_downscale_rgb565.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/pbd_pkg.sv */
package pbd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int GRAPHICS_BASE = 32;
  localparam int TEXT_BASE     = 0;
  localparam int BLANK_INDEX   = 16;
  localparam int SUM_W         = 10;
  localparam int COLOUR_W      = 32;
  localparam int LOOKUPS       = 4;

  localparam logic [31:0] SPLIT_MASK = 32'h07e0f81f;
  localparam logic [7:0]  TEXT_NIBBLE = 8'hf0;

  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_ONE_BOX  = 3'd1;
  localparam logic [2:0] MODE_TWO_BOX  = 3'd2;
  localparam logic [2:0] MODE_ONE_PAIR = 3'd3;
  localparam logic [2:0] MODE_TEXT     = 3'd4;
  localparam logic [2:0] MODE_TWO_PAIR = 3'd5;
  localparam logic [2:0] MODE_RESET    = MODE_ONE_BOX;

  typedef enum logic [1:0] {
    FOLD_OFF,
    FOLD_PAIR,
    FOLD_BOX
  } fold_t;

  typedef logic [PAL_AW-1:0] pal_idx_t;

  typedef struct packed {
    logic [LOOKUPS-1:0][PAL_AW-1:0] addr;
    fold_t                          kind;
  } lookup_t;

  function automatic pal_idx_t pal_idx(input logic [SUM_W-1:0] s);
    return s[PAL_AW-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] gfx_sum(input logic [7:0] a, input logic [7:0] b);
    return SUM_W'(a) + SUM_W'(b) + SUM_W'(GRAPHICS_BASE);
  endfunction

  function automatic logic [SUM_W-1:0] text_sum(input logic [7:0] b);
    return SUM_W'(b[7:4]) + SUM_W'(TEXT_BASE);
  endfunction

  function automatic logic [15:0] fold(input fold_t kind, input logic [31:0] w);
    logic [31:0] m;
    logic [15:0] r;
    m = '0;
    r = '0;
    unique case (kind)
      FOLD_BOX: begin
        m = w & (SPLIT_MASK << 2);
        r = m[17:2] + {2'b00, m[31:18]};
      end
      FOLD_PAIR: begin
        m = w & (SPLIT_MASK << 1);
        r = m[16:1] + {1'b0, m[31:17]};
      end
      FOLD_OFF: begin
        r = w[15:0] + w[31:16];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

/* design/palette_box_downscale_rgb565.sv */
// Half-size palette downscaler with RGB565 output.
// Input channel: in_valid/in_stall carry one request per accepted cycle.
// A request with in_cmd low writes in_pal_value to palette entry
// in_pal_addr and produces no result. A request with in_cmd high carries a
// 2x2 block of plane A and plane B bytes and produces one pixel on the
// output channel, out_valid/out_stall, as out_pixel_out.
// cfg_we/cfg_wdata write the draw mode: box, pair, text-over or blank. The
// user, not the block, ensures no request is in flight while writing it.
// A pixel request reads all four palette copies; the words are combined in
// the stage-two sum register and then folded into the output register. One
// request can be taken every cycle when not stalled: the palette is
// held in four copies so that all four lookups of a block are read in
// the same cycle, and palette writes go to every copy at once.
// Reset clears the pipeline valid bits and sets the draw mode to one-plane
// box; palette contents are not cleared and must be written before use.
// When the receiver stalls, the result is held and the stages behind it
// keep filling until the pipeline is full, after which in_stall is raised.
module palette_box_downscale_rgb565 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_pal_addr,
  input  logic [31:0] in_pal_value,
  input  logic [7:0]  in_a_top_left,
  input  logic [7:0]  in_a_top_right,
  input  logic [7:0]  in_a_bot_left,
  input  logic [7:0]  in_a_bot_right,
  input  logic [7:0]  in_b_top_left,
  input  logic [7:0]  in_b_top_right,
  input  logic [7:0]  in_b_bot_left,
  input  logic [7:0]  in_b_bot_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_out
);

  `include "assert_macros.svh"

  logic [2:0]              draw_mode_r;
  pbd_pkg::lookup_t        lookup;
  logic                    in_acc, pal_we, pal_re;
  pbd_pkg::pal_idx_t       pal_waddr;
  logic [pbd_pkg::LOOKUPS-1:0][pbd_pkg::COLOUR_W-1:0] pal_rdata;

  logic                    s1_v_r, s1_v_nxt, s1_adv;
  pbd_pkg::fold_t          s1_kind_r;
  logic                    s2_v_r, s2_v_nxt, s2_adv;
  pbd_pkg::fold_t          s2_kind_r;
  logic [31:0]             s2_sum_r, s2_sum_nxt;
  logic                    out_valid_r, out_valid_nxt, out_ready;
  logic [15:0]             out_pixel_r;

  pbd_lookup u_lookup (
    .draw_mode   (draw_mode_r),
    .a_top_left  (in_a_top_left),
    .a_top_right (in_a_top_right),
    .a_bot_left  (in_a_bot_left),
    .a_bot_right (in_a_bot_right),
    .b_top_left  (in_b_top_left),
    .b_top_right (in_b_top_right),
    .b_bot_left  (in_b_bot_left),
    .b_bot_right (in_b_bot_right),
    .lookup      (lookup)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_adv    = !s2_v_r || out_ready;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_stall  = !s1_adv;
  assign in_acc    = in_valid && s1_adv;
  assign pal_we    = in_acc && (in_cmd == pbd_pkg::CMD_PAL_WRITE);
  assign pal_re    = in_acc && (in_cmd == pbd_pkg::CMD_PIXEL);
  assign pal_waddr = pbd_pkg::pal_idx(pbd_pkg::SUM_W'(in_pal_addr));

  for (genvar g = 0; g < pbd_pkg::LOOKUPS; g++) begin : g_pal
    pbd_ram #(
      .WIDTH (pbd_pkg::COLOUR_W),
      .DEPTH (pbd_pkg::PALETTE_DEPTH)
    ) u_pal (
      .clk   (clk),
      .we    (pal_we),
      .waddr (pal_waddr),
      .wdata (in_pal_value),
      .re    (pal_re),
      .raddr (lookup.addr[g]),
      .rdata (pal_rdata[g])
    );
  end

  always_comb begin
    s1_v_nxt      = s1_adv ? pal_re : s1_v_r;
    s2_v_nxt      = s2_adv ? s1_v_r : s2_v_r;
    out_valid_nxt = out_ready ? s2_v_r : out_valid_r;
    unique case (s1_kind_r)
      pbd_pkg::FOLD_BOX:  s2_sum_nxt = pal_rdata[0] + pal_rdata[1] + pal_rdata[2] + pal_rdata[3];
      pbd_pkg::FOLD_PAIR: s2_sum_nxt = pal_rdata[0] + pal_rdata[1];
      pbd_pkg::FOLD_OFF:  s2_sum_nxt = pal_rdata[0];
      default:            s2_sum_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_mode_r <= pbd_pkg::MODE_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        draw_mode_r <= cfg_wdata;
      end
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_re) begin
      s1_kind_r <= lookup.kind;
    end
    if (s2_adv && s1_v_r) begin
      s2_kind_r <= s1_kind_r;
      s2_sum_r  <= s2_sum_nxt;
    end
    if (out_ready && s2_v_r) begin
      out_pixel_r <= pbd_pkg::fold(s2_kind_r, s2_sum_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

  `ASSERT_NEXT(a_write_no_result, clk, rst_n, pal_we, !s1_v_r)
  `ASSERT_NEXT(a_pixel_enters, clk, rst_n, pal_re, s1_v_r)
  `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_v_r && !s2_adv, s1_v_r && $stable(s1_kind_r))
  `ASSERT_NEXT(a_s2_fills, clk, rst_n, s1_v_r && s2_adv, s2_v_r)
  `ASSERT_SAME(a_full_stalls, clk, rst_n, s1_v_r && s2_v_r && out_valid_r && out_stall,
               in_stall)

endmodule

/* design/pbd_ram.sv */
module pbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/pbd_lookup.sv */
module pbd_lookup (
  input  logic [2:0]       draw_mode,
  input  logic [7:0]       a_top_left,
  input  logic [7:0]       a_top_right,
  input  logic [7:0]       a_bot_left,
  input  logic [7:0]       a_bot_right,
  input  logic [7:0]       b_top_left,
  input  logic [7:0]       b_top_right,
  input  logic [7:0]       b_bot_left,
  input  logic [7:0]       b_bot_right,
  output pbd_pkg::lookup_t lookup
);

  pbd_pkg::pal_idx_t one_tl, one_tr, one_bl, one_br;
  pbd_pkg::pal_idx_t two_tl, two_tr, two_bl, two_br;
  pbd_pkg::pal_idx_t text_l, text_r, blank;
  logic              text_l_on, text_r_on;

  assign one_tl = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_top_left, 8'd0));
  assign one_tr = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_top_right, 8'd0));
  assign one_bl = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_bot_left, 8'd0));
  assign one_br = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_bot_right, 8'd0));
  assign two_tl = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_top_left, b_top_left));
  assign two_tr = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_top_right, b_top_right));
  assign two_bl = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_bot_left, b_bot_left));
  assign two_br = pbd_pkg::pal_idx(pbd_pkg::gfx_sum(a_bot_right, b_bot_right));
  assign text_l = pbd_pkg::pal_idx(pbd_pkg::text_sum(b_bot_left));
  assign text_r = pbd_pkg::pal_idx(pbd_pkg::text_sum(b_bot_right));
  assign blank  = pbd_pkg::pal_idx(pbd_pkg::SUM_W'(pbd_pkg::BLANK_INDEX));

  assign text_l_on = |(b_bot_left & pbd_pkg::TEXT_NIBBLE);
  assign text_r_on = |(b_bot_right & pbd_pkg::TEXT_NIBBLE);

  always_comb begin
    unique case (draw_mode)
      pbd_pkg::MODE_ONE_BOX: begin
        lookup.addr = {one_br, one_bl, one_tr, one_tl};
        lookup.kind = pbd_pkg::FOLD_BOX;
      end
      pbd_pkg::MODE_TWO_BOX: begin
        lookup.addr = {two_br, two_bl, two_tr, two_tl};
        lookup.kind = pbd_pkg::FOLD_BOX;
      end
      pbd_pkg::MODE_ONE_PAIR: begin
        lookup.addr = {one_br, one_bl, one_tr, one_tl};
        lookup.kind = pbd_pkg::FOLD_PAIR;
      end
      pbd_pkg::MODE_TEXT: begin
        lookup.addr = {text_r_on ? text_r : one_tr,
                       text_l_on ? text_l : one_tl,
                       two_tr, two_tl};
        lookup.kind = pbd_pkg::FOLD_BOX;
      end
      pbd_pkg::MODE_TWO_PAIR: begin
        lookup.addr = {two_br, two_bl, two_tr, two_tl};
        lookup.kind = pbd_pkg::FOLD_PAIR;
      end
      default: begin
        lookup.addr = {blank, blank, blank, blank};
        lookup.kind = pbd_pkg::FOLD_OFF;
      end
    endcase
  end

endmodule
